### src/b64u_pkg.sv
// Shared types, status codes and the character map for the base64url decoder.
// No dependencies; every other file in src imports this package.
package b64u_pkg;

  // Final status codes reported on the end-of-message result
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_LEN      = 2'd2;
  localparam logic [1:0] ST_TRAIL    = 2'd3;

  localparam int unsigned LEN_W = 13;
  localparam logic [LEN_W-1:0] COUNT_MAX = '1;

  // Largest decoded length that gives a nonzero required character count
  localparam int unsigned MAX_DECODED_LEN = 4096;

  // Length register reset value and its required character count
  localparam int unsigned RESET_LEN = 32;
  localparam int unsigned RESET_REQ = (RESET_LEN / 3) * 4 +
                                      ((RESET_LEN % 3) != 0 ? (RESET_LEN % 3) + 1 : 0);

  // ceil(2^15 / 3); exact quotient for every 13-bit value
  localparam logic [13:0] RECIP3 = 14'd10923;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic [1:0] status;
  } result_t;

  // base64url alphabet to sextet; ok low for anything outside the alphabet
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2d) begin
      s.val = 6'd62;
    end else if (c == 8'h5f) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

### src/b64u_len_cfg.sv
// Length configuration register: turns the decoded length into the required
// character count at write time. Depends on b64u_pkg.
module b64u_len_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [b64u_pkg::LEN_W-1:0] expected_decoded_len,
  output logic [b64u_pkg::LEN_W-1:0] req_len
);
  import b64u_pkg::*;

  logic [26:0]      prod;
  logic [11:0]      quot;
  logic [LEN_W-1:0] rem_full;
  logic [1:0]       rem;
  logic [13:0]      req_calc;
  logic             in_range;
  logic [LEN_W-1:0] req_len_next;

  assign cfg_ready = 1'b1;

  // Divide by 3 through a reciprocal multiply
  always_comb begin
    prod     = 27'(expected_decoded_len) * 27'(RECIP3);
    quot     = prod[26:15];
    rem_full = expected_decoded_len - LEN_W'({quot, 1'b0}) - LEN_W'(quot);
    rem      = rem_full[1:0];
    req_calc = {quot, 2'b00} + ((rem != 2'd0) ? 14'(rem) + 14'd1 : 14'd0);
    in_range = (expected_decoded_len != '0) &&
               (32'(expected_decoded_len) <= MAX_DECODED_LEN);
    req_len_next = in_range ? req_calc[LEN_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_len <= LEN_W'(RESET_REQ);
    end else if (cfg_valid && cfg_ready) begin
      req_len <= req_len_next;
    end
  end

endmodule

### src/b64u_decode_stage.sv
// Input register, per-message state and the decode logic for one character.
// Depends on b64u_pkg.
module b64u_decode_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                char_code,
  input  logic                      last_char,
  input  logic [b64u_pkg::LEN_W-1:0] req_len,
  input  logic                      room,
  output logic                      res_valid,
  output b64u_pkg::result_t         res
);
  import b64u_pkg::*;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       s1_fire;

  // Message state
  logic [1:0]       quad_position;
  logic [5:0]       held_sextet;
  logic [LEN_W-1:0] char_count;
  logic [1:0]       error_code;

  logic [1:0]       quad_position_next;
  logic [5:0]       held_sextet_next;
  logic [LEN_W-1:0] char_count_next;
  logic [1:0]       error_code_next;

  sextet_t    sx;
  logic [7:0] byte_val;
  logic       has_byte;
  logic [1:0] fin_status;
  logic       len_bad;
  logic       trail_bad;

  assign s1_fire  = s1_valid && room;
  assign in_stall = s1_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char <= char_code;
      s1_last <= last_char;
    end
  end

  // Decode one character against the stored state
  always_comb begin
    sx              = sextet_of(s1_char);
    char_count_next = (char_count == COUNT_MAX) ? char_count : char_count + 1'b1;

    error_code_next = error_code;
    if (!sx.ok && error_code_next == ST_OK) begin
      error_code_next = ST_BAD_CHAR;
    end
    if ((char_count_next == COUNT_MAX || char_count_next > req_len) &&
        error_code_next == ST_OK) begin
      error_code_next = ST_LEN;
    end

    case (quad_position)
      2'd1:    byte_val = {held_sextet, sx.val[5:4]};
      2'd2:    byte_val = {held_sextet[3:0], sx.val[5:2]};
      2'd3:    byte_val = {held_sextet[1:0], sx.val};
      default: byte_val = 8'd0;
    endcase
    has_byte = sx.ok && (quad_position != 2'd0) && (error_code_next == ST_OK);

    // End-of-message status, length mismatch first
    len_bad   = (char_count_next == COUNT_MAX) || (char_count_next != req_len);
    trail_bad = ((quad_position == 2'd1) && (sx.val[3:0] != 4'd0)) ||
                ((quad_position == 2'd2) && (sx.val[1:0] != 2'd0));
    fin_status = ST_OK;
    if (s1_last) begin
      if (len_bad) begin
        fin_status = ST_LEN;
      end else if (error_code_next != ST_OK) begin
        fin_status = error_code_next;
      end else if (trail_bad) begin
        fin_status = ST_TRAIL;
      end
    end
    if (fin_status != ST_OK) begin
      has_byte = 1'b0;
    end

    res_valid          = s1_fire && (has_byte || s1_last);
    res.data_byte      = has_byte ? byte_val : 8'd0;
    res.byte_valid     = has_byte;
    res.end_of_message = s1_last;
    res.status         = fin_status;

    if (s1_last) begin
      quad_position_next = 2'd0;
      held_sextet_next   = 6'd0;
    end else begin
      quad_position_next = quad_position + 2'd1;
      held_sextet_next   = sx.val;
    end
  end

  // State update; cleared after each last character
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_position <= 2'd0;
      held_sextet   <= 6'd0;
      char_count    <= '0;
      error_code    <= ST_OK;
    end else if (s1_fire) begin
      quad_position <= quad_position_next;
      held_sextet   <= held_sextet_next;
      char_count    <= s1_last ? '0 : char_count_next;
      error_code    <= s1_last ? ST_OK : error_code_next;
    end
  end

endmodule

### src/b64u_out_reg.sv
// Result register between the decode logic and the output channel.
// Depends on b64u_pkg.
module b64u_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  b64u_pkg::result_t res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        data_byte,
  output logic              byte_valid,
  output logic              end_of_message,
  output logic [1:0]        status
);
  import b64u_pkg::*;

  result_t held;

  // Free when empty or when the held transaction leaves this cycle
  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && res_valid) begin
      held <= res;
    end
  end

  assign data_byte      = held.data_byte;
  assign byte_valid     = held.byte_valid;
  assign end_of_message = held.end_of_message;
  assign status         = held.status;

endmodule

### src/base64url_strict_decoder.sv
// Top level of the unpadded base64url decoder: config register, decode stage
// and result register. Depends on b64u_pkg and the b64u_* modules.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_stall    | char_code, last_char
//  out     | out_valid / out_stall  | data_byte, byte_valid, end_of_message, status
//  cfg     | cfg_valid / cfg_ready  | expected_decoded_len
//
// One character per cycle while in_stall is low; a result passes through the
// input register, then the result register, before it reaches the outputs.
// rst is synchronous: clears the message state, drops both valid flags and
// sets the decoded length to 32.
// out_stall holds a full result register and, once the input register is full,
// raises in_stall in the same cycle. cfg_ready is always high.
module base64url_strict_decoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                char_code,
  input  logic                      last_char,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                data_byte,
  output logic                      byte_valid,
  output logic                      end_of_message,
  output logic [1:0]                status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [b64u_pkg::LEN_W-1:0] expected_decoded_len
);
  import b64u_pkg::*;

  logic [LEN_W-1:0] req_len;
  logic             room;
  logic             res_valid;
  result_t          res;

  b64u_len_cfg u_cfg (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .expected_decoded_len (expected_decoded_len),
    .req_len              (req_len)
  );

  b64u_decode_stage u_dec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .req_len   (req_len),
    .room      (room),
    .res_valid (res_valid),
    .res       (res)
  );

  b64u_out_reg u_out (
    .clk            (clk),
    .rst            (rst),
    .res_valid      (res_valid),
    .res            (res),
    .room           (room),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .status         (status)
  );

  // A delivered byte never carries a failing status
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> status == ST_OK)
    else $error("byte delivered with nonzero status");

  // Results before the end of a message always carry a byte
  a_mid_has_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_message |-> byte_valid && status == ST_OK)
    else $error("empty result inside a message");

  // No byte means a zero data field
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> data_byte == 8'd0)
    else $error("data_byte nonzero without a byte");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

### verif/tb.sv
// Self-checking testbench for base64url_strict_decoder: a directed table, then
// random messages, checked against a cycle-free decode predictor.
// Depends on b64u_pkg and the RTL under src.
`timescale 1ns / 100ps

module tb;
  import b64u_pkg::*;

  // How a transaction's expected result is obtained
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FIXED} chk_e;
  typedef enum logic {ROW_CFG, ROW_CHAR} row_op_e;
  typedef enum logic [2:0] {MSG_GOOD, MSG_BADCHAR, MSG_TRAIL, MSG_LEN, MSG_NOISE} msg_kind_e;

  typedef struct {
    row_op_e    op;
    logic [12:0] val;     // length for ROW_CFG, character for ROW_CHAR
    logic       lst;
    chk_e       chk;
    result_t    res;
  } row_t;

  typedef struct {
    chk_e    chk;
    result_t res;
  } char_chk_t;

  localparam int N_ROWS       = 32;
  localparam int RANDOM_CHARS = 850;
  localparam int FINAL_CHARS  = 100;
  localparam int HOLD_CYCLES  = 60;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       char_code;
  logic             last_char;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       data_byte;
  logic             byte_valid;
  logic             end_of_message;
  logic [1:0]       status;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] expected_decoded_len;

  // Predictor state
  logic [LEN_W-1:0] len_reg;
  logic [1:0]       q_pos;
  logic [5:0]       prev_sextet;
  logic [LEN_W-1:0] seen_chars;
  logic [1:0]       msg_err;

  result_t   decoded_q[$];
  char_chk_t char_chk_q[$];
  int        errors;
  int        chars_sent;
  bit        idling;
  bit        long_hold_req;

  // Directed plan; fixed results only where they are obvious
  row_t plan [0:N_ROWS-1] = '{
    // reset length 32: a single character is a length mismatch
    '{ROW_CHAR, 13'h041, 1'b1, CHK_FIXED, '{8'h00, 1'b0, 1'b1, ST_LEN}},
    '{ROW_CFG,  13'd1,   1'b0, CHK_MODEL, '0},
    // "QQ" decodes to 'A'
    '{ROW_CHAR, 13'h051, 1'b0, CHK_NONE,  '0},
    '{ROW_CHAR, 13'h051, 1'b1, CHK_FIXED, '{8'h41, 1'b1, 1'b1, ST_OK}},
    // "QR" leaves nonzero unused bits
    '{ROW_CHAR, 13'h051, 1'b0, CHK_NONE,  '0},
    '{ROW_CHAR, 13'h052, 1'b1, CHK_FIXED, '{8'h00, 1'b0, 1'b1, ST_TRAIL}},
    // byte extremes are both outside the alphabet
    '{ROW_CHAR, 13'h0ff, 1'b0, CHK_NONE,  '0},
    '{ROW_CHAR, 13'h000, 1'b1, CHK_FIXED, '{8'h00, 1'b0, 1'b1, ST_BAD_CHAR}},
    // one character too many
    '{ROW_CHAR, 13'h041, 1'b0, CHK_NONE,  '0},
    '{ROW_CHAR, 13'h041, 1'b0, CHK_FIXED, '{8'h00, 1'b1, 1'b0, ST_OK}},
    '{ROW_CHAR, 13'h041, 1'b1, CHK_FIXED, '{8'h00, 1'b0, 1'b1, ST_LEN}},
    '{ROW_CFG,  13'd2,   1'b0, CHK_MODEL, '0},
    // "__8": all-ones bytes
    '{ROW_CHAR, 13'h05f, 1'b0, CHK_NONE,  '0},
    '{ROW_CHAR, 13'h05f, 1'b0, CHK_FIXED, '{8'hff, 1'b1, 1'b0, ST_OK}},
    '{ROW_CHAR, 13'h038, 1'b1, CHK_FIXED, '{8'hff, 1'b1, 1'b1, ST_OK}},
    '{ROW_CFG,  13'd3,   1'b0, CHK_MODEL, '0},
    // full quad over the '-', digit and lowercase ranges
    '{ROW_CHAR, 13'h02d, 1'b0, CHK_MODEL, '0},
    '{ROW_CHAR, 13'h039, 1'b0, CHK_MODEL, '0},
    '{ROW_CHAR, 13'h07a, 1'b0, CHK_MODEL, '0},
    '{ROW_CHAR, 13'h061, 1'b1, CHK_MODEL, '0},
    // bad character suppresses the rest of the message
    '{ROW_CHAR, 13'h041, 1'b0, CHK_NONE,  '0},
    '{ROW_CHAR, 13'h02a, 1'b0, CHK_NONE,  '0},
    '{ROW_CHAR, 13'h05a, 1'b0, CHK_NONE,  '0},
    '{ROW_CHAR, 13'h030, 1'b1, CHK_FIXED, '{8'h00, 1'b0, 1'b1, ST_BAD_CHAR}},
    // lengths 0, 4097 and 8191 are out of range and need zero characters; 4096 is in range
    '{ROW_CFG,  13'd0,   1'b0, CHK_MODEL, '0},
    '{ROW_CHAR, 13'h041, 1'b1, CHK_FIXED, '{8'h00, 1'b0, 1'b1, ST_LEN}},
    '{ROW_CFG,  13'd4097, 1'b0, CHK_MODEL, '0},
    '{ROW_CHAR, 13'h041, 1'b1, CHK_FIXED, '{8'h00, 1'b0, 1'b1, ST_LEN}},
    '{ROW_CFG,  13'd4096, 1'b0, CHK_MODEL, '0},
    '{ROW_CHAR, 13'h041, 1'b1, CHK_FIXED, '{8'h00, 1'b0, 1'b1, ST_LEN}},
    '{ROW_CFG,  13'd8191, 1'b0, CHK_MODEL, '0},
    '{ROW_CHAR, 13'h041, 1'b1, CHK_FIXED, '{8'h00, 1'b0, 1'b1, ST_LEN}}
  };

  base64url_strict_decoder u_dut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .char_code            (char_code),
    .last_char            (last_char),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .data_byte            (data_byte),
    .byte_valid           (byte_valid),
    .end_of_message       (end_of_message),
    .status               (status),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .expected_decoded_len (expected_decoded_len)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Alphabet lookup via the low six bits of each ASCII range
  function automatic void map_char(input logic [7:0] c, output logic ok,
                                   output logic [5:0] v);
    ok = 1'b1;
    v  = '0;
    if (c >= 8'h41 && c <= 8'h5a) v = c[5:0] - 6'd1;
    else if (c >= 8'h61 && c <= 8'h7a) v = c[5:0] - 6'd7;
    else if (c >= 8'h30 && c <= 8'h39) v = c[5:0] + 6'd4;
    else if (c == 8'h2d) v = 6'd62;
    else if (c == 8'h5f) v = 6'd63;
    else ok = 1'b0;
  endfunction

  function automatic logic [7:0] to_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    return (v == 6'd62) ? 8'h2d : 8'h5f;
  endfunction

  // Unpadded encoded length; zero for lengths out of range
  function automatic int chars_needed(input logic [LEN_W-1:0] len);
    int n;
    n = len;
    if (n == 0 || n > MAX_DECODED_LEN) return 0;
    return (n / 3) * 4 + ((n % 3) != 0 ? (n % 3) + 1 : 0);
  endfunction

  // One character through the decode predictor; emit set if a result is due
  function automatic void decode_char(input logic [7:0] c, input logic lst,
                                      output logic emit, output result_t res);
    logic             ok;
    logic [5:0]       v;
    logic [1:0]       pos;
    logic [LEN_W-1:0] cnt;
    logic [7:0]       b;
    logic [1:0]       st;
    int               need;
    map_char(c, ok, v);
    pos  = q_pos;
    need = chars_needed(len_reg);
    cnt  = (seen_chars != COUNT_MAX) ? seen_chars + 1'b1 : seen_chars;
    if (!ok && msg_err == ST_OK) msg_err = ST_BAD_CHAR;
    if ((cnt == COUNT_MAX || int'(cnt) > need) && msg_err == ST_OK) msg_err = ST_LEN;

    b    = '0;
    emit = 1'b0;
    if (ok) begin
      case (pos)
        2'd1: b = {prev_sextet, v[5:4]};
        2'd2: b = {prev_sextet[3:0], v[5:2]};
        2'd3: b = {prev_sextet[1:0], v};
        default: b = '0;
      endcase
      emit = (pos != 2'd0);
    end
    if (msg_err != ST_OK) emit = 1'b0;

    prev_sextet = v;
    q_pos       = pos + 2'd1;
    seen_chars  = cnt;

    // end of message: final status, then clear the message state
    st = ST_OK;
    if (lst) begin
      if (cnt == COUNT_MAX || int'(cnt) != need) st = ST_LEN;
      else if (msg_err != ST_OK) st = msg_err;
      else if (pos == 2'd1 && v[3:0] != 4'd0) st = ST_TRAIL;
      else if (pos == 2'd2 && v[1:0] != 2'd0) st = ST_TRAIL;
      if (st != ST_OK) emit = 1'b0;
      q_pos       = '0;
      prev_sextet = '0;
      seen_chars  = '0;
      msg_err     = ST_OK;
    end

    res.data_byte      = emit ? b : 8'h00;
    res.byte_valid     = emit;
    res.end_of_message = lst;
    res.status         = st;
    emit = emit | lst;
  endfunction

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    errors++;
    if (errors <= 200)
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report(name, got, want);
  endtask

  // Monitor: config and input transactions feed the predictor, results are checked
  always @(posedge clk) begin : monitor
    result_t   seen;
    result_t   want;
    char_chk_t how;
    logic      emit;
    if (rst) begin
      len_reg     = LEN_W'(RESET_LEN);
      q_pos       = '0;
      prev_sextet = '0;
      seen_chars  = '0;
      msg_err     = ST_OK;
      decoded_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {data_byte, byte_valid, end_of_message, status};
        if (decoded_q.size() == 0) begin
          report("result with none pending", seen.data_byte, 8'h00);
        end else begin
          want = decoded_q.pop_front();
          check_field("data_byte", seen.data_byte, want.data_byte);
          check_field("byte_valid", 8'(seen.byte_valid), 8'(want.byte_valid));
          check_field("end_of_message", 8'(seen.end_of_message), 8'(want.end_of_message));
          check_field("status", 8'(seen.status), 8'(want.status));
        end
      end
      if (cfg_valid && cfg_ready) len_reg = expected_decoded_len;
      if (in_valid && !in_stall) begin
        if (char_chk_q.size() != 0) how = char_chk_q.pop_front();
        else how = '{CHK_MODEL, '0};
        decode_char(char_code, last_char, emit, want);
        if (how.chk == CHK_FIXED) begin
          emit = 1'b1;
          want = how.res;
        end else if (how.chk == CHK_NONE) begin
          emit = 1'b0;
        end
        if (emit) decoded_q.push_back(want);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one character and wait for its transaction
  task automatic send_char(input logic [7:0] ch, input logic lst, input chk_e chk,
                           input result_t res);
    int gap;
    gap = (idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    char_chk_q.push_back('{chk, res});
    in_valid  <= 1'b1;
    char_code <= ch;
    last_char <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  // Stop sending and let every pending result drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] v);
    settle();
    cfg_valid            <= 1'b1;
    expected_decoded_len <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One message of n characters shaped by kind
  task automatic send_msg(input msg_kind_e kind, input int n);
    int         bad_at;
    logic [5:0] v;
    logic [7:0] ch;
    logic       ok;
    bad_at = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      v = 6'($urandom_range(0, 63));
      if (i == n - 1) begin
        if (kind == MSG_TRAIL) begin
          if (n % 4 == 2) v[3:0] = 4'($urandom_range(1, 15));
          if (n % 4 == 3) v[1:0] = 2'($urandom_range(1, 3));
        end else begin
          if (n % 4 == 2) v[3:0] = '0;
          if (n % 4 == 3) v[1:0] = '0;
        end
      end
      ch = to_char(v);
      if (kind == MSG_BADCHAR && i == bad_at) begin
        do begin
          ch = 8'($urandom_range(0, 255));
          map_char(ch, ok, v);
        end while (ok);
      end
      if (kind == MSG_NOISE) ch = 8'($urandom_range(0, 255));
      send_char(ch, i == n - 1, CHK_MODEL, '0);
    end
  endtask

  task automatic random_msgs(input int count, input bit vary_len);
    int        start;
    int        r;
    int        need;
    int        n;
    int        d;
    bit        hold_done;
    msg_kind_e kind;
    start     = chars_sent;
    hold_done = !vary_len;
    while (chars_sent - start < count) begin
      // long receiver hold-off while a byte-heavy message keeps coming
      if (!hold_done && chars_sent - start >= 300) begin
        write_len(13'd24);
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
        send_msg(MSG_GOOD, chars_needed(len_reg));
      end
      // occasional new length, mostly small
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 99);
        if (!vary_len || r < 80) write_len(13'($urandom_range(1, 24)));
        else if (r < 92) write_len(13'($urandom_range(25, 200)));
        else if (r < 96) write_len('0);
        else write_len(13'($urandom_range(4097, 8191)));
      end
      r = vary_len ? $urandom_range(0, 99) : 0;
      if (r < 70) kind = MSG_GOOD;
      else if (r < 78) kind = MSG_BADCHAR;
      else if (r < 86) kind = MSG_TRAIL;
      else if (r < 94) kind = MSG_LEN;
      else kind = MSG_NOISE;
      need = chars_needed(len_reg);
      if (kind == MSG_NOISE || need == 0) begin
        n = $urandom_range(1, 8);
      end else if (kind == MSG_LEN) begin
        d = $urandom_range(1, 3);
        n = $urandom_range(0, 1) ? need + d : need - d;
        if (n < 1) n = 1;
      end else begin
        n = need;
      end
      send_msg(kind, n);
    end
  endtask

  // Stimulus
  initial begin
    rst                  = 1'b1;
    in_valid             = 1'b0;
    char_code            = '0;
    last_char            = 1'b0;
    cfg_valid            = 1'b0;
    expected_decoded_len = '0;
    idling               = 1'b1;
    long_hold_req        = 1'b0;
    errors               = 0;
    chars_sent           = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      if (plan[i].op == ROW_CFG) write_len(plan[i].val);
      else send_char(plan[i].val[7:0], plan[i].lst, plan[i].chk, plan[i].res);
    end

    random_msgs(RANDOM_CHARS, 1'b1);

    // back to back, no idling on either side
    idling = 1'b0;
    random_msgs(FINAL_CHARS, 1'b0);

    settle();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

endmodule
